FILE: hw/rtl/psrm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and field widths for the particle SDF ray marcher.
// No dependencies; every other file except psrm_ram refers to this package by scoped names.
package psrm_pkg;

  localparam int MAX_PARTICLES_DEF = 256;
  localparam int MARCH_STEPS_DEF   = 10;

  localparam int COORD_W    = 32;
  localparam int DIST_W     = 64;
  localparam int VAL_W      = 52;
  localparam int COUNT_W    = 9;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int ADDR_W_MAX = 16;
  localparam int POS_W      = 3 * COORD_W;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 8'd1;

  localparam logic [CFG_DATA_W-1:0] RADIUS_SQ_RESET = 32'd65536;
  localparam logic [COUNT_W-1:0]    COUNT_RESET     = 9'd256;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CAST = 1'b1;

  localparam int ISSUE_GAP = 3;

  // Smooth minimum, k = 0.1 in Q16.16; floor(t*t / 4k) = floor((t*t >> 3) / 3277)
  localparam int SMIN_K         = 6554;
  localparam int SMIN_T_W       = 13;
  localparam int SMIN_SQ_W      = 26;
  localparam int SMIN_DIV_SHIFT = 35;
  localparam int SMIN_RECIP_W   = 24;
  localparam logic [SMIN_RECIP_W-1:0] SMIN_RECIP = 24'd10485121;

  localparam logic signed [DIST_W-1:0] FIELD_FAR = 64'sh7FFF_FFFF_FFFF_FFFF;

  localparam int SQRT_ITERS = 40;
  localparam int SQRT_OP_W  = 80;
  localparam int ROOT_W     = 40;
  localparam int REM_W      = 44;

  typedef struct packed {
    logic                      opcode;
    logic [7:0]                particle_index;
    logic signed [COORD_W-1:0] particle_x;
    logic signed [COORD_W-1:0] particle_y;
    logic signed [COORD_W-1:0] particle_z;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DIST_W-1:0] march_distance;
  } result_t;

  typedef struct packed {
    logic                  load;
    logic                  ray_start;
    logic                  fold_init;
    logic                  rd_en;
    logic [ADDR_W_MAX-1:0] rd_addr;
    logic                  accum;
    logic                  sqrt_load;
    logic                  sqrt_step;
    logic                  mv_mul;
    logic                  mv_add;
    logic                  out_load;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic field_le0;
    logic out_full;
  } status_t;

endpackage

FILE: hw/rtl/psrm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for items, results and register writes.
// Depends on psrm_pkg for the payload types.
interface psrm_item_if;
  logic                 valid;
  logic                 ready;
  psrm_pkg::item_t      data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psrm_result_if;
  logic                 valid;
  logic                 ready;
  psrm_pkg::result_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psrm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [psrm_pkg::CFG_IDX_W-1:0]      index;
  logic [psrm_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/psrm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psrm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/psrm_dp.sv
`timescale 1ns / 1ps
// Datapath: particle store, field pipeline, smooth-min fold, square root,
// origin update and result register. Depends on psrm_pkg and psrm_ram.
module psrm_dp #(
  parameter int MAX_PARTICLES = psrm_pkg::MAX_PARTICLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  psrm_pkg::item_t                     item_data,
  input  logic [psrm_pkg::CFG_DATA_W-1:0]     radius_squared,
  input  psrm_pkg::cmd_t                      cmd,
  output psrm_pkg::status_t                   st,
  output logic                                res_valid,
  input  logic                                res_ready,
  output psrm_pkg::result_t                   res_data
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = psrm_pkg::COORD_W;
  localparam int DW = psrm_pkg::DIST_W;
  localparam int VW = psrm_pkg::VAL_W;

  // store
  logic                        ram_we;
  logic [psrm_pkg::POS_W-1:0]  ram_rdata;

  assign ram_we = cmd.load && (32'(item_data.particle_index) < 32'(MAX_PARTICLES));

  psrm_ram #(
    .WIDTH (psrm_pkg::POS_W),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(item_data.particle_index)),
    .wdata ({item_data.particle_x, item_data.particle_y, item_data.particle_z}),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // ray state
  logic signed [CW-1:0] org  [3];
  logic signed [CW-1:0] dirv [3];

  // field pipeline
  logic                 rd_pend, v1, v2, v3, fa, fb;
  logic [CW-1:0]        mag  [3];
  logic [2*CW-1:0]      prod [3];
  logic signed [VW-1:0] val;
  logic signed [CW-1:0] pos  [3];
  logic signed [CW:0]   diff [3];
  logic [VW-3:0]        sq_sum;

  assign pos[0] = ram_rdata[3*CW-1:2*CW];
  assign pos[1] = ram_rdata[2*CW-1:CW];
  assign pos[2] = ram_rdata[CW-1:0];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = {pos[c][CW-1], pos[c]} - {org[c][CW-1], org[c]};
    end
    sq_sum = (VW-2)'(prod[0][2*CW-1:16]) + (VW-2)'(prod[1][2*CW-1:16])
           + (VW-2)'(prod[2][2*CW-1:16]);
  end

  // fold
  logic signed [DW-1:0]                  field;
  logic signed [DW-1:0]                  val64, lo, hi, lo_a, lo_b;
  logic [DW-1:0]                         dgap;
  logic                                  near_a, near_b;
  logic [psrm_pkg::SMIN_T_W-1:0]         t_a;
  logic [psrm_pkg::SMIN_SQ_W-1:0]        tsq_b;
  logic [psrm_pkg::SMIN_SQ_W-3+psrm_pkg::SMIN_RECIP_W-1:0] qprod;
  logic [DW-1:0]                         q;

  assign val64 = {{(DW-VW){val[VW-1]}}, val};
  assign lo    = (val64 < field) ? val64 : field;
  assign hi    = (val64 < field) ? field : val64;
  assign dgap  = hi - lo;
  assign qprod = (psrm_pkg::SMIN_SQ_W-3+psrm_pkg::SMIN_RECIP_W)'(tsq_b[psrm_pkg::SMIN_SQ_W-1:3])
               * (psrm_pkg::SMIN_SQ_W-3+psrm_pkg::SMIN_RECIP_W)'(psrm_pkg::SMIN_RECIP);
  assign q     = DW'(qprod >> psrm_pkg::SMIN_DIV_SHIFT);

  // distance
  logic signed [DW-1:0] dist_acc;
  logic                 hit_r;
  logic signed [DW:0]   dsum;

  assign dsum = {dist_acc[DW-1], dist_acc} + {field[DW-1], field};

  // square root
  logic [psrm_pkg::SQRT_OP_W-1:0] sq_op;
  logic [psrm_pkg::REM_W-1:0]     rem, rem_sh, trial;
  logic [psrm_pkg::ROOT_W-1:0]    root;

  assign rem_sh = {rem[psrm_pkg::REM_W-3:0], sq_op[psrm_pkg::SQRT_OP_W-1 -: 2]};
  assign trial  = psrm_pkg::REM_W'({root, 2'b01});

  // move
  logic [55:0]          ph [3];
  logic [47:0]          pl [3];
  logic                 dneg [3];
  logic [CW-1:0]        dmag [3];
  logic [56:0]          mstep [3];
  logic signed [58:0]   mres [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dmag[c]  = dirv[c][CW-1] ? (~dirv[c] + 32'd1) : dirv[c];
      mstep[c] = 57'(ph[c]) + 57'(pl[c][47:16]);
      mres[c]  = dneg[c] ? (59'(org[c]) - $signed({2'b00, mstep[c]}))
                         : (59'(org[c]) + $signed({2'b00, mstep[c]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      fa        <= 1'b0;
      fb        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en;
      v1      <= rd_pend;
      v2      <= v1;
      v3      <= v2;
      fa      <= v3;
      fb      <= fa;
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end

    if (cmd.ray_start) begin
      org[0]   <= item_data.origin_x;
      org[1]   <= item_data.origin_y;
      org[2]   <= item_data.origin_z;
      dirv[0]  <= item_data.dir_x;
      dirv[1]  <= item_data.dir_y;
      dirv[2]  <= item_data.dir_z;
      dist_acc <= '0;
      hit_r    <= 1'b0;
    end

    for (int c = 0; c < 3; c++) begin
      mag[c]  <= diff[c][CW] ? CW'(-diff[c]) : CW'(diff[c]);
      prod[c] <= (2*CW)'(mag[c]) * (2*CW)'(mag[c]);
    end
    val <= $signed({2'b00, sq_sum}) - $signed({(VW-CW)'(0), radius_squared});

    lo_a   <= lo;
    near_a <= dgap < DW'(psrm_pkg::SMIN_K);
    t_a    <= psrm_pkg::SMIN_T_W'(psrm_pkg::SMIN_K) - dgap[psrm_pkg::SMIN_T_W-1:0];
    lo_b   <= lo_a;
    near_b <= near_a;
    tsq_b  <= psrm_pkg::SMIN_SQ_W'(t_a) * psrm_pkg::SMIN_SQ_W'(t_a);

    if (cmd.fold_init) begin
      field <= psrm_pkg::FIELD_FAR;
    end else if (fb) begin
      field <= near_b ? (lo_b - $signed(q)) : lo_b;
    end

    if (cmd.accum) begin
      if (dsum[DW] != dsum[DW-1]) begin
        dist_acc <= dsum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
        dist_acc <= dsum[DW-1:0];
      end
      if (field <= 0) begin
        hit_r <= 1'b1;
      end
    end

    if (cmd.sqrt_load) begin
      sq_op <= {field, 16'd0};
      rem   <= '0;
      root  <= '0;
    end else if (cmd.sqrt_step) begin
      sq_op <= {sq_op[psrm_pkg::SQRT_OP_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[psrm_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[psrm_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    for (int c = 0; c < 3; c++) begin
      if (cmd.mv_mul) begin
        ph[c]   <= 56'(dmag[c]) * 56'(root[psrm_pkg::ROOT_W-1:16]);
        pl[c]   <= 48'(dmag[c]) * 48'(root[15:0]);
        dneg[c] <= dirv[c][CW-1];
      end
      if (cmd.mv_add) begin
        if (mres[c] > 59'sd2147483647) begin
          org[c] <= 32'sh7FFF_FFFF;
        end else if (mres[c] < -59'sd2147483648) begin
          org[c] <= 32'sh8000_0000;
        end else begin
          org[c] <= mres[c][CW-1:0];
        end
      end
    end

    if (cmd.out_load) begin
      res_data.hit            <= hit_r;
      res_data.march_distance <= dist_acc;
    end
  end

  assign st.busy      = rd_pend | v1 | v2 | v3 | fa | fb;
  assign st.field_le0 = field <= 0;
  assign st.out_full  = res_valid;

endmodule

FILE: hw/rtl/psrm_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences loads, particle reads, square root, move and result.
// Depends on psrm_pkg for command and status types.
module psrm_ctrl #(
  parameter int MAX_PARTICLES = psrm_pkg::MAX_PARTICLES_DEF,
  parameter int MARCH_STEPS   = psrm_pkg::MARCH_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  input  logic                             opcode,
  output logic                             item_ready,
  input  logic [psrm_pkg::COUNT_W-1:0]     particle_count,
  input  psrm_pkg::status_t                st,
  output psrm_pkg::cmd_t                   cmd
);

  localparam int CNTW = $clog2(MAX_PARTICLES + 1);
  localparam int SW   = (MARCH_STEPS > 1) ? $clog2(MARCH_STEPS) : 1;
  localparam int IW   = $clog2(psrm_pkg::SQRT_ITERS);

  typedef enum logic [2:0] {
    IDLE, STEP_INIT, ISSUE, DRAIN, SQRT, MOVE_MUL, MOVE_ADD, RESULT
  } state_t;

  state_t          state;
  logic [CNTW-1:0] idx;
  logic [1:0]      phase;
  logic [SW-1:0]   step_cnt;
  logic [IW-1:0]   iter;
  logic [CNTW-1:0] eff_count;
  logic            last_step;

  assign eff_count = (32'(particle_count) > 32'(MAX_PARTICLES)) ? CNTW'(MAX_PARTICLES)
                                                              : CNTW'(particle_count);
  assign last_step = step_cnt == SW'(MARCH_STEPS - 1);
  assign item_ready = state == IDLE;

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: begin
        cmd.load      = item_valid && (opcode == psrm_pkg::OP_LOAD);
        cmd.ray_start = item_valid && (opcode == psrm_pkg::OP_CAST);
      end
      STEP_INIT: cmd.fold_init = 1'b1;
      ISSUE: begin
        cmd.rd_en   = phase == 2'd0;
        cmd.rd_addr = psrm_pkg::ADDR_W_MAX'(idx);
      end
      DRAIN: begin
        cmd.accum     = !st.busy;
        cmd.sqrt_load = !st.busy && !st.field_le0 && !last_step;
      end
      SQRT:     cmd.sqrt_step = 1'b1;
      MOVE_MUL: cmd.mv_mul = 1'b1;
      MOVE_ADD: cmd.mv_add = 1'b1;
      RESULT:   cmd.out_load = !st.out_full;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      idx      <= '0;
      phase    <= '0;
      step_cnt <= '0;
      iter     <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (item_valid && (opcode == psrm_pkg::OP_CAST)) begin
            step_cnt <= '0;
            state    <= STEP_INIT;
          end
        end
        STEP_INIT: begin
          idx   <= '0;
          phase <= '0;
          state <= (eff_count == '0) ? DRAIN : ISSUE;
        end
        ISSUE: begin
          phase <= (phase == 2'(psrm_pkg::ISSUE_GAP - 1)) ? 2'd0 : phase + 2'd1;
          if (phase == 2'd0) begin
            idx <= idx + CNTW'(1);
            if (idx == eff_count - CNTW'(1)) begin
              state <= DRAIN;
            end
          end
        end
        DRAIN: begin
          if (!st.busy) begin
            if (st.field_le0 || last_step) begin
              state <= RESULT;
            end else begin
              iter  <= '0;
              state <= SQRT;
            end
          end
        end
        SQRT: begin
          iter <= iter + IW'(1);
          if (iter == IW'(psrm_pkg::SQRT_ITERS - 1)) begin
            state <= MOVE_MUL;
          end
        end
        MOVE_MUL: state <= MOVE_ADD;
        MOVE_ADD: begin
          step_cnt <= step_cnt + SW'(1);
          state    <= STEP_INIT;
        end
        RESULT: begin
          if (!st.out_full) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/particle_sdf_ray_march.sv
`timescale 1ns / 1ps
// Particle SDF ray marcher top level: register file, controller and datapath.
// A ray takes up to MARCH_STEPS steps over N particles; each step reads the particles
// one at a time, spaced out for the smooth-min fold loop, and every step but the last
// that goes on adds a bit-serial square root and an origin move.
// One transaction at a time; a finished result waits in an output register.
// Synchronous reset: registers at defaults; particle store keeps its contents.
module particle_sdf_ray_march #(
  parameter int MAX_PARTICLES = psrm_pkg::MAX_PARTICLES_DEF,
  parameter int MARCH_STEPS   = psrm_pkg::MARCH_STEPS_DEF
) (
  input logic           clk,
  input logic           rst,
  psrm_item_if.sink     item,
  psrm_result_if.source result,
  psrm_cfg_if.sink      cfg
);

  logic [psrm_pkg::CFG_DATA_W-1:0] radius_squared;
  logic [psrm_pkg::COUNT_W-1:0]    particle_count;
  psrm_pkg::cmd_t                  cmd;
  psrm_pkg::status_t               st;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_squared <= psrm_pkg::RADIUS_SQ_RESET;
      particle_count <= psrm_pkg::COUNT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        psrm_pkg::REG_RADIUS_SQ:      radius_squared <= cfg.data;
        psrm_pkg::REG_PARTICLE_COUNT: particle_count <= cfg.data[psrm_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  psrm_ctrl #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .MARCH_STEPS   (MARCH_STEPS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item.valid),
    .opcode         (item.data.opcode),
    .item_ready     (item.ready),
    .particle_count (particle_count),
    .st             (st),
    .cmd            (cmd)
  );

  psrm_dp #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .item_data      (item.data),
    .radius_squared (radius_squared),
    .cmd            (cmd),
    .st             (st),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_data       (result.data)
  );

endmodule
